// ===== rtl/core/gbs_pkg.sv =====
// shared types, constants and coefficient helpers for the gaussian blur stream
package gbs_pkg;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KERNEL = 2'd2
  } cfg_reg_t;

  localparam int QDEPTH = 8;
  localparam int QAW = 3;
  localparam logic [23:0] WHITE = 24'hFFFFFF;

  typedef struct packed {
    logic        last;
    logic [23:0] data;
  } out_beat_t;

  // kernel weights in millionths
  localparam int unsigned W5 [25] = '{
    3765,  15019, 23792,  15019, 3765,
    15019, 59913, 94907,  59913, 15019,
    23792, 94907, 150343, 94907, 23792,
    15019, 59913, 94907,  59913, 15019,
    3765,  15019, 23792,  15019, 3765};
  localparam int unsigned W3 [9] = '{
    62500,  125000, 62500,
    125000, 250000, 125000,
    62500,  125000, 62500};

  // weight rounded half-up to unsigned fixed point with frac fraction bits
  function automatic int unsigned coef_q(input bit five, input int k, input int a,
                                         input int frac);
    longint unsigned m;
    m = 0;
    if (five) begin
      if (k < 5 && a < 5) m = W5[k*5+a];
    end else if (k < 3 && a < 3) begin
      m = W3[k*3+a];
    end
    return int'(((m << frac) + 64'd500000) / 64'd1000000);
  endfunction

endpackage

// ===== rtl/core/gbs_window.sv =====
// line stores and tap window holding the pixel neighborhood
module gbs_window
  import gbs_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         acc,
  input  logic [23:0]                  pix,
  input  logic [$clog2(MAX_WIDTH)-1:0] col,
  output logic [23:0]                  win [MAX_KERNEL][MAX_KERNEL]
);

  localparam int K  = MAX_KERNEL;
  localparam int NB = MAX_KERNEL - 1;
  localparam int AW = $clog2(MAX_WIDTH);

  logic          s1_v;
  logic [23:0]   s1_pix;
  logic [AW-1:0] s1_col;
  logic [23:0]   rd   [NB];
  logic [23:0]   colv [K];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix <= pix;
      s1_col <= col;
    end
  end

  // column of the newest item: itself, then one row back per entry
  always_comb begin
    colv[0] = s1_pix;
    for (int j = 0; j < NB; j++) begin
      colv[j+1] = rd[j];
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_bank
    logic [23:0] mem [MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (s1_v) begin
        mem[s1_col] <= colv[j];
      end
      if (acc) begin
        // forward the write still in flight to the same column
        rd[j] <= (s1_v && s1_col == col) ? colv[j] : mem[col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      for (int k = 0; k < K; k++) begin
        for (int a = K - 1; a > 0; a--) begin
          win[k][a] <= win[k][a-1];
        end
        win[k][0] <= colv[k];
      end
    end
  end

endmodule

// ===== rtl/core/gbs_lane.sv =====
// one color channel: weighted taps, row sums, truncation and saturation
module gbs_lane
  import gbs_pkg::*;
#(
  parameter int MAX_KERNEL     = 5,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic [7:0]            taps [MAX_KERNEL][MAX_KERNEL],
  input  logic [MAX_KERNEL-1:0] row_ok,
  input  logic [MAX_KERNEL-1:0] col_ok,
  input  logic                  five,
  output logic [7:0]            result
);

  localparam int K  = MAX_KERNEL;
  localparam int CW = COEF_FRAC_BITS;
  localparam int PW = CW + 8;
  localparam int SW = PW + 3;
  localparam int TW = PW + 5;

  logic [PW-1:0] prod [K][K];
  logic [SW-1:0] rsum [K];
  logic [TW-1:0] total;
  logic [TW-1:0] whole;

  for (genvar k = 0; k < K; k++) begin : g_row
    for (genvar a = 0; a < K; a++) begin : g_tap
      localparam logic [CW-1:0] C5 = CW'(coef_q(1'b1, k, a, COEF_FRAC_BITS));
      localparam logic [CW-1:0] C3 = CW'(coef_q(1'b0, k, a, COEF_FRAC_BITS));
      logic [7:0] pv;

      // taps off the image read white
      assign pv = (row_ok[k] && col_ok[a]) ? taps[k][a] : 8'hFF;

      always_ff @(posedge clk) begin
        prod[k][a] <= PW'(five ? C5 : C3) * PW'(pv);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [SW-1:0] s;
    for (int k = 0; k < K; k++) begin
      s = '0;
      for (int a = 0; a < K; a++) begin
        s = s + SW'(prod[k][a]);
      end
      rsum[k] <= s;
    end
  end

  always_comb begin
    total = '0;
    for (int k = 0; k < K; k++) begin
      total = total + TW'(rsum[k]);
    end
    whole  = total >> CW;
    result = (whole > TW'(255)) ? 8'hFF : whole[7:0];
  end

endmodule

// ===== rtl/core/gbs_merge.sv =====
// joins the three channel results into an output beat and queues it
module gbs_merge
  import gbs_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [7:0]     red,
  input  logic [7:0]     green,
  input  logic [7:0]     blue,
  input  logic           last,
  output logic [QAW:0]   count,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [23:0]    m_axis_tdata,
  output logic           m_axis_tlast
);

  out_beat_t        q [QDEPTH];
  logic [QAW-1:0]   wp;
  logic [QAW-1:0]   rp;
  logic             pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = q[rp].data;
  assign m_axis_tlast  = q[rp].last;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{last: last, data: {blue, green, red}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

// ===== rtl/core/rgb_gaussian_blur_stream.sv =====
// top level: 3x3 / 5x5 gaussian blur of a raster rgb stream
// a completing beat passes window input, tap, product, row-sum and queue registers
// throughput: one beat per cycle in and out while credit remains and tready is high;
//   a result queue of 8 beats with credit flow control parts input from output
// reset: synchronous, clears counters, pipeline valids and the result queue;
//   line stores are not cleared, taps off the image are masked to white
module rgb_gaussian_blur_stream
  import gbs_pkg::*;
#(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_HEIGHT     = 4096,
  parameter int MAX_KERNEL     = 5,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic        s_axis_tuser,   // func [0]: 1 for a flush beat
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
  output logic        m_axis_tlast,   // frame_last
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int K  = MAX_KERNEL;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int LW = $clog2(2*MAX_WIDTH + 3);
  localparam int XW = ((HW > WW) ? HW : WW) + 2;

  // registers
  logic [10:0] img_width;
  logic [12:0] img_height;
  logic        kernel_sel;
  logic        cfg_wr;

  // effective geometry from the registers
  logic [WW-1:0] w_r;
  logic [HW-1:0] h_r;
  logic          five_r;
  logic [LW-1:0] lag_r;
  logic [1:0]    half;

  // frame position
  logic [AW-1:0] in_col;
  logic [LW-1:0] fill;
  logic [AW-1:0] out_col;
  logic [RW-1:0] out_row;
  logic          acc;
  logic          emit;
  logic          last;
  logic [23:0]   pix;

  // border masks for the emitted pixel
  logic [K-1:0]  row_ok_n;
  logic [K-1:0]  col_ok_n;
  logic [K-1:0]  s1_row_ok;
  logic [K-1:0]  s1_col_ok;
  logic [K-1:0]  s2_row_ok;
  logic [K-1:0]  s2_col_ok;

  // valid / last pipeline that tracks the datapath
  logic s1_v, s1_e, s2_e, l1_e, l2_e;
  logic s1_last, s2_last, l1_last, l2_last;

  logic [QAW:0]   q_count;
  logic [QAW+1:0] used;

  logic [23:0] win [K][K];
  logic [7:0]  taps_r [K][K];
  logic [7:0]  taps_g [K][K];
  logic [7:0]  taps_b [K][K];
  logic [7:0]  res_r, res_g, res_b;

  // ---------------- register port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= 11'd640;
      img_height <= 13'd480;
      kernel_sel <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(paddr[3:2]))
        REG_WIDTH:  img_width  <= pwdata[10:0];
        REG_HEIGHT: img_height <= pwdata[12:0];
        REG_KERNEL: kernel_sel <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(paddr[3:2]))
      REG_WIDTH:  prdata = 32'(img_width);
      REG_HEIGHT: prdata = 32'(img_height);
      REG_KERNEL: prdata = 32'(kernel_sel);
      default:    prdata = '0;
    endcase
  end

  // zero reads as one, oversize clamps to MAX_WIDTH and MAX_HEIGHT
  always_comb begin
    if (img_width == '0) w_r = WW'(1);
    else if (32'(img_width) > MAX_WIDTH) w_r = WW'(MAX_WIDTH);
    else w_r = WW'(img_width);

    if (img_height == '0) h_r = HW'(1);
    else if (32'(img_height) > MAX_HEIGHT) h_r = HW'(MAX_HEIGHT);
    else h_r = HW'(img_height);

    five_r = kernel_sel && (MAX_KERNEL >= 5);
    lag_r  = five_r ? (LW'({w_r, 1'b0}) + LW'(2)) : (LW'(w_r) + LW'(1));
  end

  assign half = five_r ? 2'd2 : 2'd1;

  // ---------------- input side ----------------
  // credit: queue entries plus results still in the pipe
  assign used = (QAW+2)'(q_count) + (QAW+2)'(s1_e) + (QAW+2)'(s2_e)
              + (QAW+2)'(l1_e) + (QAW+2)'(l2_e);
  assign s_axis_tready = (used < (QAW+2)'(QDEPTH));
  assign acc  = s_axis_tvalid && s_axis_tready;
  assign pix  = s_axis_tuser ? WHITE : s_axis_tdata;
  assign emit = (fill == lag_r);
  assign last = emit && (WW'(out_col) == w_r - WW'(1)) && (HW'(out_row) == h_r - HW'(1));

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      in_col  <= '0;
      fill    <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (acc) begin
      if (last) begin
        // frame done, next beat opens a new frame
        in_col  <= '0;
        fill    <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        in_col <= (WW'(in_col) == w_r - WW'(1)) ? '0 : in_col + 1'b1;
        if (!emit) begin
          fill <= fill + 1'b1;
        end else if (WW'(out_col) == w_r - WW'(1)) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  // window row k sits k rows above the newest, column a sits a pixels back
  always_comb begin
    logic [XW-1:0] rr;
    logic [XW-1:0] cc;
    rr = XW'(out_row) + XW'(half);
    cc = XW'(out_col) + XW'(half);
    for (int k = 0; k < K; k++) begin
      row_ok_n[k] = (rr >= XW'(k)) && (rr < XW'(h_r) + XW'(k));
      col_ok_n[k] = (cc >= XW'(k)) && (cc < XW'(w_r) + XW'(k));
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_row_ok <= row_ok_n;
      s1_col_ok <= col_ok_n;
      s1_last   <= last;
    end
    if (s1_v) begin
      s2_row_ok <= s1_row_ok;
      s2_col_ok <= s1_col_ok;
    end
    s2_last <= s1_last;
    l1_last <= s2_last;
    l2_last <= l1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s1_e <= 1'b0;
      s2_e <= 1'b0;
      l1_e <= 1'b0;
      l2_e <= 1'b0;
    end else begin
      s1_v <= acc;
      s1_e <= acc && emit;
      s2_e <= s1_e;
      l1_e <= s2_e;
      l2_e <= l1_e;
    end
  end

  // ---------------- datapath ----------------
  gbs_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_window (
    .clk (clk),
    .rst (rst),
    .acc (acc),
    .pix (pix),
    .col (in_col),
    .win (win)
  );

  always_comb begin
    for (int k = 0; k < K; k++) begin
      for (int a = 0; a < K; a++) begin
        taps_r[k][a] = win[k][a][7:0];
        taps_g[k][a] = win[k][a][15:8];
        taps_b[k][a] = win[k][a][23:16];
      end
    end
  end

  gbs_lane #(.MAX_KERNEL(MAX_KERNEL), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_r (
    .clk (clk), .taps (taps_r), .row_ok (s2_row_ok), .col_ok (s2_col_ok),
    .five (five_r), .result (res_r)
  );

  gbs_lane #(.MAX_KERNEL(MAX_KERNEL), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_g (
    .clk (clk), .taps (taps_g), .row_ok (s2_row_ok), .col_ok (s2_col_ok),
    .five (five_r), .result (res_g)
  );

  gbs_lane #(.MAX_KERNEL(MAX_KERNEL), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_b (
    .clk (clk), .taps (taps_b), .row_ok (s2_row_ok), .col_ok (s2_col_ok),
    .five (five_r), .result (res_b)
  );

  gbs_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .push          (l2_e),
    .red           (res_r),
    .green         (res_g),
    .blue          (res_b),
    .last          (l2_last),
    .count         (q_count),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/core/gbs_checker.sv =====
// port-level checks for the gaussian blur stream, bound to the top level
module gbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // reset empties the result queue
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // an empty queue fills only from an earlier accepted input beat
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 5))
    else $error("result without matching input beat");

endmodule

bind rgb_gaussian_blur_stream gbs_checker u_gbs_checker (.*);

// ===== sim/rgb_gaussian_blur_stream_tb.sv =====
// testbench for rgb_gaussian_blur_stream: directed and random frames checked against a predictor
module rgb_gaussian_blur_stream_tb;
  import gbs_pkg::*;

  localparam int LINE_DEPTH = 4 * 1024 + 5;   // four rows of the widest image plus a window
  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 20;           // pipeline latency with margin

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit       last;
  } blur_px_t;

  // reference blur with its own line memory, counters and register copies
  class blur_scoreboard;
    bit [23:0]       line_mem [LINE_DEPTH];
    int unsigned     item_idx;
    int unsigned     width, height;
    bit              five;
    longint unsigned c5 [25];
    longint unsigned c3 [9];
    blur_px_t        pending [$];
    int              errors;
    int              checked;

    function new();
      int unsigned m5 [25] = '{
        3765,  15019, 23792,  15019, 3765,
        15019, 59913, 94907,  59913, 15019,
        23792, 94907, 150343, 94907, 23792,
        15019, 59913, 94907,  59913, 15019,
        3765,  15019, 23792,  15019, 3765};
      int unsigned m3 [9] = '{62500, 125000, 62500, 125000, 250000, 125000,
                              62500, 125000, 62500};
      foreach (m5[i]) c5[i] = ((longint'(m5[i]) << FRAC) + 500000) / 1000000;
      foreach (m3[i]) c3[i] = ((longint'(m3[i]) << FRAC) + 500000) / 1000000;
      item_idx = 0;
      width = 640;
      height = 480;
      five = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(cfg_reg_t r, int unsigned v);
      case (r)
        REG_WIDTH: begin
          width = v & 11'h7FF;
        end
        REG_HEIGHT: begin
          height = v & 13'h1FFF;
        end
        default: begin
          five = v[0];
        end
      endcase
    endfunction

    function bit [7:0] clip(longint unsigned acc);
      longint unsigned v;
      v = acc >> FRAC;
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // accepted input beat: store it and predict the pixel that it completes
    function void note_input(bit flush, bit [23:0] d);
      int unsigned     w, h, half, lag, wh, n, p, q;
      int              orow, ocol, ty, tx, kk;
      longint unsigned sr, sg, sb, c;
      bit [23:0]       v;
      blur_px_t        e;
      w = (width < 1) ? 1 : (width > 1024) ? 1024 : width;
      h = (height < 1) ? 1 : (height > 4096) ? 4096 : height;
      half = five ? 2 : 1;
      kk = 2 * half + 1;
      lag = half * w + half;
      wh = w * h;
      n = (item_idx >= lag + wh) ? 0 : item_idx;
      line_mem[n % LINE_DEPTH] = flush ? 24'hFFFFFF : d;
      if (n < lag) begin
        item_idx = n + 1;
        return;
      end
      p = n - lag;
      orow = p / w;
      ocol = p % w;
      sr = 0;
      sg = 0;
      sb = 0;
      for (int dy = -int'(half); dy <= int'(half); dy++) begin
        for (int dx = -int'(half); dx <= int'(half); dx++) begin
          c = five ? c5[(dy + 2) * kk + dx + 2] : c3[(dy + 1) * kk + dx + 1];
          ty = orow + dy;
          tx = ocol + dx;
          // taps off the image read white
          if (ty < 0 || tx < 0 || ty >= int'(h) || tx >= int'(w)) begin
            v = 24'hFFFFFF;
          end else begin
            q = ty * w + tx;
            v = line_mem[q % LINE_DEPTH];
          end
          sr += c * v[7:0];
          sg += c * v[15:8];
          sb += c * v[23:16];
        end
      end
      e.red = clip(sr);
      e.green = clip(sg);
      e.blue = clip(sb);
      e.last = (p == wh - 1);
      pending.push_back(e);
      item_idx = e.last ? 0 : n + 1;
    endfunction

    function void check_result(bit [23:0] d, bit last);
      blur_px_t e;
      if (pending.size() == 0) begin
        $error("unexpected output beat data=%h last=%0b", d, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[7:0] != e.red) begin
        $error("out_red expected %0d actual %0d", e.red, d[7:0]);
        errors++;
      end
      if (d[15:8] != e.green) begin
        $error("out_green expected %0d actual %0d", e.green, d[15:8]);
        errors++;
      end
      if (d[23:16] != e.blue) begin
        $error("out_blue expected %0d actual %0d", e.blue, d[23:16]);
        errors++;
      end
      if (last != e.last) begin
        $error("frame_last expected %0b actual %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;     // red [7:0], green [15:8], blue [23:16]
  logic        s_axis_tuser = 1'b0;   // func [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;          // out_red [7:0], out_green [15:8], out_blue [23:16]
  logic        m_axis_tlast;          // frame_last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  blur_scoreboard sb = new();
  int  cycles = 0;
  int  beats_in = 0;
  int  frames = 0;
  bit  idle_on = 1'b0;     // random gaps on both streams
  bit  hold_req = 1'b0;    // asks the receiver for one long hold-off

  rgb_gaussian_blur_stream u_dut (.*);

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, sb.pending.size());
      $display("** rgb_gaussian_blur_stream: FAILED **");
      $finish;
    end
  end

  // receiver: check accepted beats, then pick next tready
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      if (hold_req) begin
        // long stall so the result queue fills and the input backs up
        hold = 400;
        hold_req = 1'b0;
      end else if (hold == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 19);
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // two-phase register write; lands at the access edge
  task automatic reg_write(cfg_reg_t r, int unsigned v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(r) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(r, v);
  endtask

  // offer one beat and hold it until accepted
  task automatic send_beat(bit flush, bit [23:0] d);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= flush;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(flush, d);
    beats_in++;
  endtask

  // wait for every predicted beat, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one whole frame: pixels then a tail of mostly flush beats; pattern 1 gives black/white extremes
  task automatic run_frame(int unsigned w, int unsigned h, bit k, int flush_pct, int pattern);
    int unsigned ew, eh, total;
    bit          flush;
    bit [23:0]   d;
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_KERNEL, k);
    ew = (w < 1) ? 1 : (w > 1024) ? 1024 : w;
    eh = (h < 1) ? 1 : (h > 4096) ? 4096 : h;
    total = ew * eh + (k ? 2 : 1) * (ew + 1);
    for (int unsigned i = 0; i < total; i++) begin
      d = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255))};
      if (pattern == 1) d = i[0] ? 24'hFFFFFF : 24'h000000;
      if (i < ew * eh) begin
        // a flush beat inside the image acts as a white pixel
        flush = ($urandom_range(0, 99) < flush_pct);
      end else begin
        // tail: mostly flush beats, some plain pixels whose data is never read
        flush = ($urandom_range(0, 9) != 0);
      end
      send_beat(flush, d);
    end
    drain();
    frames++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, both kernels, flush inside the image
    run_frame(3, 3, 1'b0, 30, 1);
    run_frame(2, 2, 1'b1, 25, 1);
    // out-of-range sizes: zero width and zero height read as one
    run_frame(0, 30, 1'b1, 5, 0);
    run_frame(40, 0, 1'b0, 5, 0);

    // random frames, mostly small
    while (beats_in < 1300) begin
      idle_on = (beats_in < 1150) ? ($urandom_range(0, 3) != 0) : 1'b0;
      if (frames == 8) begin
        idle_on = 1'b1;
        hold_req = 1'b1;
        run_frame(16, 8, 1'b1, 10, 0);
      end else begin
        run_frame($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(0, 1),
                  $urandom_range(0, 20), 0);
      end
    end
    idle_on = 1'b0;
    drain();

    $display("covered %0d frames, %0d input beats, %0d output pixels checked", frames,
             beats_in, sb.checked);
    $display("both kernels, zero sizes, a long output stall, flush beats in and after the image");
    if (sb.errors == 0) begin
      $display("** rgb_gaussian_blur_stream: PASSED **");
    end else begin
      $display("** rgb_gaussian_blur_stream: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/gbs_pkg.sv
rtl/core/gbs_window.sv
rtl/core/gbs_lane.sv
rtl/core/gbs_merge.sv
rtl/core/rgb_gaussian_blur_stream.sv
rtl/core/gbs_checker.sv
sim/rgb_gaussian_blur_stream_tb.sv
